/* rtl/core/priority_sorted_queue_unit_assert.svh */
// Assertion helpers used by the checker file.
`ifndef PRIORITY_SORTED_QUEUE_UNIT_ASSERT_SVH
`define PRIORITY_SORTED_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define PSQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/psq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package psq_pkg;

  localparam int unsigned ENTRY_W = 72;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LIST   = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_CMP,
    S_LIST_RD,
    S_LIST_PUT,
    S_STATUS
  } state_e;

  // id sits in the low bits, prio in the high bits
  typedef struct packed {
    logic [7:0]  prio;
    logic [23:0] left;
    logic [23:0] total;
    logic [15:0] id;
  } entry_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef struct packed {
    logic    load;
    status_e status;
    logic    last;
  } out_ld_t;

endpackage

`default_nettype wire

/* rtl/core/psq_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module psq_store import psq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire mem_ctl_t      ctl_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire entry_t        wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output entry_t             rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/psq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module psq_ctrl import psq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire action_e       in_action_i,
  input  wire entry_t        in_entry_i,
  input  wire logic          out_free_i,
  output out_ld_t            out_ld_o,
  output entry_t             out_entry_o,
  output mem_ctl_t           mem_ctl_o,
  output logic [AW-1:0]      mem_waddr_o,
  output logic [AW-1:0]      mem_raddr_o,
  output entry_t             mem_wdata_o,
  input  wire entry_t        mem_rdata_i
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_e        state_q, state_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] fill_q, fill_d;
  status_e       stat_q, stat_d;
  entry_t        new_q, new_d;

  logic          full;
  logic          empty;
  logic          ptr_zero;
  logic          last_hit;
  logic          ge;
  logic [CW-1:0] ptr_m1;
  logic [CW-1:0] ptr_p1;

  assign full     = (fill_q == CW'(DEPTH));
  assign empty    = (fill_q == '0);
  assign ptr_zero = (ptr_q == '0);
  assign ptr_m1   = ptr_q - CW'(1);
  assign ptr_p1   = ptr_q + CW'(1);
  assign last_hit = (ptr_p1 == fill_q);
  // shared compare: stored entry shifts up while its prio is not below the new one
  assign ge       = (mem_rdata_i.prio >= new_q.prio);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_action_i == ACT_INSERT) begin
            state_d = full ? S_STATUS : S_INS_SCAN;
          end else begin
            state_d = empty ? S_STATUS : S_LIST_RD;
          end
        end
      end
      S_INS_SCAN: begin
        state_d = ptr_zero ? S_IDLE : S_INS_CMP;
      end
      S_INS_CMP: begin
        state_d = ge ? S_INS_SCAN : S_IDLE;
      end
      S_LIST_RD: begin
        state_d = S_LIST_PUT;
      end
      S_LIST_PUT: begin
        if (out_free_i) begin
          state_d = last_hit ? S_IDLE : S_LIST_RD;
        end
      end
      S_STATUS: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    mem_ctl_o       = '0;
    mem_waddr_o     = ptr_q[AW-1:0];
    mem_raddr_o     = ptr_q[AW-1:0];
    mem_wdata_o     = new_q;
    out_ld_o.load   = 1'b0;
    out_ld_o.status = ST_OK;
    out_ld_o.last   = 1'b0;
    out_entry_o     = mem_rdata_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
      end
      S_INS_SCAN: begin
        if (ptr_zero) begin
          mem_ctl_o.we = 1'b1;
        end else begin
          mem_ctl_o.re = 1'b1;
          mem_raddr_o  = ptr_m1[AW-1:0];
        end
      end
      S_INS_CMP: begin
        mem_ctl_o.we = 1'b1;
        mem_wdata_o  = ge ? mem_rdata_i : new_q;
      end
      S_LIST_RD: begin
        mem_ctl_o.re = 1'b1;
      end
      S_LIST_PUT: begin
        out_ld_o.load = out_free_i;
        out_ld_o.last = last_hit;
      end
      S_STATUS: begin
        out_ld_o.load   = out_free_i;
        out_ld_o.status = stat_q;
        out_ld_o.last   = 1'b1;
        out_entry_o     = '0;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    ptr_d  = ptr_q;
    fill_d = fill_q;
    stat_d = stat_q;
    new_d  = new_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          new_d  = in_entry_i;
          ptr_d  = (in_action_i == ACT_INSERT) ? fill_q : '0;
          stat_d = (in_action_i == ACT_INSERT) ? ST_FULL : ST_EMPTY;
        end
      end
      S_INS_SCAN: begin
        if (ptr_zero) begin
          fill_d = fill_q + CW'(1);
        end
      end
      S_INS_CMP: begin
        if (ge) begin
          ptr_d = ptr_m1;
        end else begin
          fill_d = fill_q + CW'(1);
        end
      end
      S_LIST_PUT: begin
        if (out_free_i && !last_hit) begin
          ptr_d = ptr_p1;
        end
      end
      default: begin
        ptr_d = ptr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ptr_q   <= '0;
      fill_q  <= '0;
      stat_q  <= ST_OK;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      fill_q  <= fill_d;
      stat_q  <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q <= new_d;
  end

endmodule

`default_nettype wire

/* rtl/core/priority_sorted_queue_unit.sv */
// Insert: each entry shifted up takes one read and one compare; the new entry
//   lands where the compare fails or at the front. One request at a time.
// List: each entry is read, then loaded into the output register; a full or
//   empty status is a single result. Output stalls hold the sequencer.
// Reset (rst_ni low, async) clears the fill count, sequencer and output valid;
//   table contents are undefined until written and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module priority_sorted_queue_unit import psq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [15:0] process_id, [39:16] total_time, [63:40] time_left, [71:64] prio
  input  wire logic [ENTRY_W-1:0]  s_axis_tdata_i,
  // [0] action
  input  wire logic                s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [15:0] out_id, [39:16] out_total, [63:40] out_left, [71:64] out_prio
  output logic [ENTRY_W-1:0]       m_axis_tdata_o,
  // [1:0] status
  output logic [1:0]               m_axis_tuser_o,
  output logic                     m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;
  out_ld_t       out_ld;
  entry_t        out_entry;
  logic          out_free;

  logic          m_valid_q;
  entry_t        m_data_q;
  status_e       m_user_q;
  logic          m_last_q;

  assign out_free = !m_valid_q || m_axis_tready_i;

  psq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_action_i (action_e'(s_axis_tuser_i)),
    .in_entry_i  (entry_t'(s_axis_tdata_i)),
    .out_free_i  (out_free),
    .out_ld_o    (out_ld),
    .out_entry_o (out_entry),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_raddr_o (mem_raddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  psq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register decouples the sink from the sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_ld.load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld.load) begin
      m_data_q <= out_entry;
      m_user_q <= out_ld.status;
      m_last_q <= out_ld.last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

`default_nettype wire

/* rtl/core/psq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "priority_sorted_queue_unit_assert.svh"

module psq_checker import psq_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tvalid_i,
  input wire logic               s_axis_tready_o,
  input wire logic [ENTRY_W-1:0] s_axis_tdata_i,
  input wire logic               s_axis_tuser_i,
  input wire logic               m_axis_tvalid_o,
  input wire logic               m_axis_tready_i,
  input wire logic [ENTRY_W-1:0] m_axis_tdata_o,
  input wire logic [1:0]         m_axis_tuser_o,
  input wire logic               m_axis_tlast_o
);

  logic in_req;
  logic in_is_list;

  assign in_req     = s_axis_tvalid_i && s_axis_tready_o;
  assign in_is_list = (s_axis_tuser_i == ACT_LIST) && (s_axis_tdata_i == s_axis_tdata_i);

  // the block is not ready again in the cycle after accepting a request
  `PSQ_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, in_req && (in_is_list || !in_is_list),
    !s_axis_tready_o, "block ready right after accepting a request")

  // a listing in progress holds off new requests
  `PSQ_ASSERT_IMP(a_list_blocks, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tlast_o,
    !s_axis_tready_o, "request taken while a listing is unfinished")

  // full and empty results are single, final and carry a zero payload
  `PSQ_ASSERT_IMP(a_status_shape, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tuser_o != ST_OK),
    m_axis_tlast_o && (m_axis_tdata_o == '0), "status result malformed")

  `PSQ_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
    $stable(m_axis_tlast_o), "stalled result changed")

endmodule

bind priority_sorted_queue_unit psq_checker u_psq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire
